[sv/bcd_conversion_arithmetic_unit_assert.svh]
// Assertion macros shared by the BCD conversion and arithmetic unit.
`ifndef BCD_CONVERSION_ARITHMETIC_UNIT_ASSERT_SVH
`define BCD_CONVERSION_ARITHMETIC_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCDAU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCDAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bcdau_pkg.sv]
// Types, constants and helper functions of the BCD conversion and arithmetic unit.
package bcdau_pkg;

  localparam int unsigned BCD_W     = 64;
  localparam int unsigned NIBS      = 16;
  localparam int unsigned VAL_W     = 54;  // holds any value below 10^16
  localparam int unsigned HALF_W    = 27;
  localparam int unsigned GRP_W     = 14;  // four decimal digits
  localparam int unsigned DD_STAGES = 6;
  localparam int unsigned DD_STEPS  = 9;   // DD_STAGES * DD_STEPS == VAL_W

  typedef enum logic [1:0] {
    CMD_BIN2BCD = 2'd0,
    CMD_BCD2BIN = 2'd1,
    CMD_ADD     = 2'd2,
    CMD_MUL     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_OVF = 2'd2
  } status_e;

  // Decoded operands leaving the decode pipeline.
  typedef struct packed {
    cmd_e               cmd;
    status_e            st;
    logic [VAL_W-1:0]   va;
    logic [VAL_W-1:0]   vb;
  } dec_t;

  // Item travelling through the double-dabble stages.
  typedef struct packed {
    cmd_e               cmd;
    status_e            st;
    logic [VAL_W-1:0]   rem;
    logic [VAL_W-1:0]   raw;
    logic [BCD_W-1:0]   bcd;
  } dd_t;

  function automatic logic [63:0] pow10(input int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < 16; i++) begin
      if (i < n) p = p * 64'd10;
    end
    return p;
  endfunction

  // True when every nibble holds a decimal digit.
  function automatic logic bcd_ok(input logic [BCD_W-1:0] v);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NIBS; i++) begin
      if (v[4*i +: 4] > 4'd9) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

[sv/bcdau_pipe_ctrl.sv]
// Valid and load-enable control for a chain of pipeline registers.
module bcdau_pipe_ctrl #(
  parameter int unsigned STAGES = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STAGES-1:0] load_o
);

  logic [STAGES-1:0] valid_q, valid_d, rdy;

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    rdy[STAGES-1] = ~valid_q[STAGES-1] | out_ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = ~valid_q[k] | rdy[k+1];
    end
    valid_d[0] = rdy[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < STAGES; k++) begin
      valid_d[k] = rdy[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign load_o      = rdy;
  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[STAGES-1];

endmodule

[sv/bcdau_decode.sv]
// Three-stage decode: digit and range checks, then packed BCD operands to binary.
module bcdau_decode #(
  parameter int unsigned DIGITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bcdau_pkg::cmd_e       cmd_i,
  input  logic [63:0]           operand_a_i,
  input  logic [63:0]           operand_b_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bcdau_pkg::dec_t       out_o
);
  import bcdau_pkg::*;

  localparam logic [63:0] Lim = pow10(DIGITS);

  typedef struct packed {
    cmd_e                  cmd;
    status_e               st;
    logic [3:0][GRP_W-1:0] ga;
    logic [3:0][GRP_W-1:0] gb;
    logic [VAL_W-1:0]      abin;
  } d1_t;

  typedef struct packed {
    cmd_e                   cmd;
    status_e                st;
    logic [1:0][HALF_W-1:0] ha;
    logic [1:0][HALF_W-1:0] hb;
    logic [VAL_W-1:0]       abin;
  } d2_t;

  logic [2:0] load;
  d1_t  s1_d, s1_q;
  d2_t  s2_d, s2_q;
  dec_t s3_d, s3_q;

  bcdau_pipe_ctrl #(.STAGES(3)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i,
    .load_o(load)
  );

  function automatic logic [GRP_W-1:0] grp4(input logic [15:0] n);
    return GRP_W'(n[15:12]) * GRP_W'(1000) + GRP_W'(n[11:8]) * GRP_W'(100)
         + GRP_W'(n[7:4]) * GRP_W'(10) + GRP_W'(n[3:0]);
  endfunction

  // Nonzero digits above the configured digit count.
  function automatic logic too_long(input logic [63:0] v);
    logic hi;
    hi = 1'b0;
    for (int i = 0; i < NIBS; i++) begin
      if (i >= DIGITS && v[4*i +: 4] != 4'd0) hi = 1'b1;
    end
    return hi;
  endfunction

  always_comb begin
    logic bad_a, bad_b, hi_a, hi_b;
    bad_a = ~bcd_ok(operand_a_i);
    bad_b = ~bcd_ok(operand_b_i);
    hi_a  = too_long(operand_a_i);
    hi_b  = too_long(operand_b_i);
    s1_d.cmd = cmd_i;
    case (cmd_i)
      CMD_BIN2BCD: s1_d.st = (operand_a_i >= Lim) ? ST_OVF : ST_OK;
      CMD_BCD2BIN: s1_d.st = bad_a ? ST_BAD : (hi_a ? ST_OVF : ST_OK);
      default:     s1_d.st = (bad_a | bad_b) ? ST_BAD : ((hi_a | hi_b) ? ST_OVF : ST_OK);
    endcase
    for (int j = 0; j < 4; j++) begin
      s1_d.ga[j] = grp4(operand_a_i[16*j +: 16]);
      s1_d.gb[j] = grp4(operand_b_i[16*j +: 16]);
    end
    s1_d.abin = operand_a_i[VAL_W-1:0];
  end

  always_comb begin
    s2_d.cmd  = s1_q.cmd;
    s2_d.st   = s1_q.st;
    s2_d.abin = s1_q.abin;
    for (int j = 0; j < 2; j++) begin
      s2_d.ha[j] = HALF_W'(s1_q.ga[2*j+1]) * HALF_W'(10000) + HALF_W'(s1_q.ga[2*j]);
      s2_d.hb[j] = HALF_W'(s1_q.gb[2*j+1]) * HALF_W'(10000) + HALF_W'(s1_q.gb[2*j]);
    end
  end

  always_comb begin
    s3_d.cmd = s2_q.cmd;
    s3_d.st  = s2_q.st;
    if (s2_q.cmd == CMD_BIN2BCD) begin
      s3_d.va = s2_q.abin;
    end else begin
      s3_d.va = VAL_W'(s2_q.ha[1]) * VAL_W'(100000000) + VAL_W'(s2_q.ha[0]);
    end
    s3_d.vb = VAL_W'(s2_q.hb[1]) * VAL_W'(100000000) + VAL_W'(s2_q.hb[0]);
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) s1_q <= s1_d;
    if (load[1]) s2_q <= s2_d;
    if (load[2]) s3_q <= s3_d;
  end

  assign out_o = s3_q;

endmodule

[sv/bcdau_mul.sv]
// Four-stage sum, split product and range check on the binary operands.
module bcdau_mul #(
  parameter int unsigned DIGITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bcdau_pkg::dec_t  in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bcdau_pkg::dd_t   out_o
);
  import bcdau_pkg::*;

  localparam logic [63:0] Lim = pow10(DIGITS);
  localparam int unsigned PW  = 2 * VAL_W;

  typedef struct packed {
    cmd_e                  cmd;
    status_e               st;
    logic [VAL_W-1:0]      va;
    logic [VAL_W:0]        sum;
    logic [VAL_W-1:0]      p00;
    logic [VAL_W-1:0]      p01;
    logic [VAL_W-1:0]      p10;
    logic [VAL_W-1:0]      p11;
  } m1_t;

  typedef struct packed {
    cmd_e                  cmd;
    status_e               st;
    logic [VAL_W-1:0]      va;
    logic [VAL_W:0]        sum;
    logic [VAL_W-1:0]      p00;
    logic [VAL_W-1:0]      p11;
    logic [VAL_W:0]        mid;
  } m2_t;

  typedef struct packed {
    cmd_e                  cmd;
    status_e               st;
    logic [VAL_W-1:0]      va;
    logic [VAL_W:0]        sum;
    logic [PW-1:0]         prod;
  } m3_t;

  logic [3:0] load;
  m1_t m1_d, m1_q;
  m2_t m2_d, m2_q;
  m3_t m3_d, m3_q;
  dd_t m4_d, m4_q;

  bcdau_pipe_ctrl #(.STAGES(4)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i,
    .load_o(load)
  );

  // Sum of the operands and partial products of their 27-bit halves.
  always_comb begin
    m1_d.cmd = in_i.cmd;
    m1_d.st  = in_i.st;
    m1_d.va  = in_i.va;
    m1_d.sum = {1'b0, in_i.va} + {1'b0, in_i.vb};
    m1_d.p00 = VAL_W'(in_i.va[HALF_W-1:0]) * VAL_W'(in_i.vb[HALF_W-1:0]);
    m1_d.p01 = VAL_W'(in_i.va[HALF_W-1:0]) * VAL_W'(in_i.vb[VAL_W-1:HALF_W]);
    m1_d.p10 = VAL_W'(in_i.va[VAL_W-1:HALF_W]) * VAL_W'(in_i.vb[HALF_W-1:0]);
    m1_d.p11 = VAL_W'(in_i.va[VAL_W-1:HALF_W]) * VAL_W'(in_i.vb[VAL_W-1:HALF_W]);
  end

  always_comb begin
    m2_d.cmd = m1_q.cmd;
    m2_d.st  = m1_q.st;
    m2_d.va  = m1_q.va;
    m2_d.sum = m1_q.sum;
    m2_d.p00 = m1_q.p00;
    m2_d.p11 = m1_q.p11;
    m2_d.mid = {1'b0, m1_q.p01} + {1'b0, m1_q.p10};
  end

  always_comb begin
    m3_d.cmd  = m2_q.cmd;
    m3_d.st   = m2_q.st;
    m3_d.va   = m2_q.va;
    m3_d.sum  = m2_q.sum;
    m3_d.prod = (PW'(m2_q.p11) << VAL_W) + (PW'(m2_q.mid) << HALF_W) + PW'(m2_q.p00);
  end

  // Final status and the value handed to the BCD encoder.
  always_comb begin
    status_e          st;
    logic [VAL_W-1:0] val;
    st = m3_q.st;
    case (m3_q.cmd)
      CMD_ADD: begin
        if (m3_q.sum >= (VAL_W+1)'(Lim)) st = ST_OVF;
        val = m3_q.sum[VAL_W-1:0];
      end
      CMD_MUL: begin
        if (m3_q.prod >= PW'(Lim)) st = ST_OVF;
        val = m3_q.prod[VAL_W-1:0];
      end
      default: val = m3_q.va;
    endcase
    if (m3_q.st != ST_OK) st = m3_q.st;
    if (st != ST_OK) val = '0;
    m4_d.cmd = m3_q.cmd;
    m4_d.st  = st;
    m4_d.rem = val;
    m4_d.raw = m3_q.va;
    m4_d.bcd = '0;
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) m1_q <= m1_d;
    if (load[1]) m2_q <= m2_d;
    if (load[2]) m3_q <= m3_d;
    if (load[3]) m4_q <= m4_d;
  end

  assign out_o = m4_q;

endmodule

[sv/bcdau_dabble.sv]
// Pipelined double-dabble encoder, a fixed number of shift steps per stage.
module bcdau_dabble (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bcdau_pkg::dd_t  in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bcdau_pkg::dd_t  out_o
);
  import bcdau_pkg::*;

  logic [DD_STAGES-1:0] load;
  dd_t stg_in [DD_STAGES];
  dd_t stg_q  [DD_STAGES];

  bcdau_pipe_ctrl #(.STAGES(DD_STAGES)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i,
    .load_o(load)
  );

  // Each step adds three to every digit of five or more, then shifts in one bit.
  function automatic dd_t dabble(input dd_t x);
    dd_t y;
    y = x;
    for (int s = 0; s < DD_STEPS; s++) begin
      for (int d = 0; d < NIBS; d++) begin
        if (y.bcd[4*d +: 4] >= 4'd5) y.bcd[4*d +: 4] = y.bcd[4*d +: 4] + 4'd3;
      end
      y.bcd = {y.bcd[BCD_W-2:0], y.rem[VAL_W-1]};
      y.rem = {y.rem[VAL_W-2:0], 1'b0};
    end
    return y;
  endfunction

  assign stg_in[0] = in_i;

  for (genvar k = 0; k < DD_STAGES; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign stg_in[k] = stg_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (load[k]) stg_q[k] <= dabble(stg_in[k]);
    end
  end

  assign out_o = stg_q[DD_STAGES-1];

endmodule

[sv/bcd_conversion_arithmetic_unit.sv]
// Top level of the BCD conversion and arithmetic unit.
//
//  Channel   Direction  tdata                                   tuser
//  s_axis    in         operand_a [63:0], operand_b [127:64]    cmd [1:0]
//  m_axis    out        result [63:0]                           status [1:0]
//
// Every beat passes through 3 decode stages, 4 stages for the sum, the split
// 54 x 54 product and the range check, and 6 double-dabble stages of 9 shift
// steps each. A new beat is accepted every cycle while the output is not stalled.
// Reset clears only the stage valid bits; no data is held across beats.
// A stall at the output backs up stage by stage, so empty stages still fill.
module bcd_conversion_arithmetic_unit #(
  parameter int unsigned DIGITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // operand_a [63:0], operand_b [127:64]
  input  logic [1:0]   s_axis_tuser,   // cmd [1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // result [63:0]
  output logic [1:0]   m_axis_tuser    // status [1:0]
);
  import bcdau_pkg::*;

  `include "bcd_conversion_arithmetic_unit_assert.svh"

  logic dec_valid, dec_ready, mul_valid, mul_ready;
  dec_t dec_out;
  dd_t  mul_out, dd_out;

  // Operand checks and conversion of both BCD operands to binary.
  bcdau_decode #(.DIGITS(DIGITS)) u_decode (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_i      (cmd_e'(s_axis_tuser)),
    .operand_a_i(s_axis_tdata[63:0]),
    .operand_b_i(s_axis_tdata[127:64]),
    .out_valid_o(dec_valid),
    .out_ready_i(dec_ready),
    .out_o      (dec_out)
  );

  // Sum, product and the exact check against 10^DIGITS.
  bcdau_mul #(.DIGITS(DIGITS)) u_mul (
    .clk_i, .rst_ni,
    .in_valid_i (dec_valid),
    .in_ready_o (dec_ready),
    .in_i       (dec_out),
    .out_valid_o(mul_valid),
    .out_ready_i(mul_ready),
    .out_o      (mul_out)
  );

  // Binary to packed BCD; its last stage is the output register.
  bcdau_dabble u_dabble (
    .clk_i, .rst_ni,
    .in_valid_i (mul_valid),
    .in_ready_o (mul_ready),
    .in_i       (mul_out),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_o      (dd_out)
  );

  // Binary results bypass the encoder; any error forces the result to zero.
  always_comb begin
    if (dd_out.st != ST_OK) begin
      m_axis_tdata = '0;
    end else if (dd_out.cmd == CMD_BCD2BIN) begin
      m_axis_tdata = 64'(dd_out.raw);
    end else begin
      m_axis_tdata = dd_out.bcd;
    end
  end

  assign m_axis_tuser = dd_out.st;

  `BCDAU_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata == 64'd0, "error beat carries a nonzero result")
  `BCDAU_ASSERT_NOW(a_bcd_digits, m_axis_tvalid && dd_out.st == ST_OK && dd_out.cmd != CMD_BCD2BIN, bcd_ok(dd_out.bcd), "encoded result holds a non-decimal digit")
  `BCDAU_ASSERT_NOW(a_full_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input held off while the pipeline has room")

endmodule

[verif/tb_bcd_conversion_arithmetic_unit.sv]
// Testbench of the BCD conversion and arithmetic unit: directed and random beats, self-checked.
module tb_bcd_conversion_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bcdau_pkg::*;

  localparam int unsigned NDIG = 16;
  localparam int unsigned LATENCY = 13;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [63:0] result;
    status_e     st;
  } outcome_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  outcome_t        pending_q[$];
  int unsigned     n_errors = 0;
  int unsigned     n_checked = 0;
  int unsigned     n_sent = 0;
  int unsigned     cmd_hits[4];
  int unsigned     st_hits[3];
  longint unsigned n_cycles = 0;
  bit              steady = 1'b0;  // no idling on either side while set

  always #1 clk_i = ~clk_i;

  bcd_conversion_arithmetic_unit #(.DIGITS(NDIG)) i_dut (.*);

  // Decodes packed BCD; returns 0 when a nibble is not a decimal digit.
  function automatic bit bcd_value(input logic [63:0] bcd, output logic [63:0] val);
    val = '0;
    for (int i = 15; i >= 0; i--) begin
      if (bcd[4*i +: 4] > 4'd9) begin
        val = '0;
        return 1'b0;
      end
      val = val * 64'd10 + 64'(bcd[4*i +: 4]);
    end
    return 1'b1;
  endfunction

  function automatic logic [63:0] to_bcd(input logic [63:0] v);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[4*i +: 4] = 4'(v % 64'd10);
      v = v / 64'd10;
    end
    return r;
  endfunction

  function automatic outcome_t bcd_outcome(input cmd_e cmd, input logic [63:0] a,
                                           input logic [63:0] b);
    logic [63:0] limit, va, vb;
    bit          oka, okb;
    outcome_t    o;
    limit = 64'd1;
    for (int i = 0; i < NDIG; i++) limit = limit * 64'd10;
    o = '{result: '0, st: ST_OK};
    case (cmd)
      CMD_BIN2BCD: begin
        if (a >= limit) o.st = ST_OVF;
        else o.result = to_bcd(a);
      end
      CMD_BCD2BIN: begin
        if (!bcd_value(a, va)) o.st = ST_BAD;
        else if (va >= limit) o.st = ST_OVF;
        else o.result = va;
      end
      default: begin
        oka = bcd_value(a, va);
        okb = bcd_value(b, vb);
        if (!oka || !okb) o.st = ST_BAD;
        else if (va >= limit || vb >= limit) o.st = ST_OVF;
        else if (cmd == CMD_ADD) begin
          if (va + vb >= limit) o.st = ST_OVF;
          else o.result = to_bcd(va + vb);
        end else begin
          if (va != 0 && vb > (limit - 64'd1) / va) o.st = ST_OVF;
          else o.result = to_bcd(va * vb);
        end
      end
    endcase
    if (o.st != ST_OK) o.result = '0;
    return o;
  endfunction

  // Drives one beat, with a random gap before it while steady is clear, and files its expected outcome.
  task automatic send_op(input cmd_e cmd, input logic [63:0] a, input logic [63:0] b);
    while (!steady && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_q.push_back(bcd_outcome(cmd, a, b));
    cmd_hits[cmd]++;
    n_sent++;
  endtask

  task automatic end_stream();
    s_axis_tvalid <= 1'b0;
  endtask

  // Packed BCD of random length: up to 16 digits, sometimes broken by a bad nibble.
  function automatic logic [63:0] rand_bcd(input int unsigned ndig, input bit allow_bad);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < ndig; i++) r[4*i +: 4] = 4'($urandom_range(9));
    if (allow_bad && $urandom_range(9) == 0)
      r[4*$urandom_range(15) +: 4] = 4'($urandom_range(15, 10));
    return r;
  endfunction

  function automatic logic [63:0] rand_wide();
    return {$urandom, $urandom} >> $urandom_range(63);
  endfunction

  task automatic test_conversions();
    send_op(CMD_BIN2BCD, 64'd0, 64'd0);
    send_op(CMD_BIN2BCD, 64'd9999999999999999, '1);
    send_op(CMD_BIN2BCD, 64'd10000000000000000, '0);
    send_op(CMD_BIN2BCD, '1, '0);
    send_op(CMD_BIN2BCD, 64'd1234567890123456, '0);
    send_op(CMD_BCD2BIN, 64'h0, '1);
    send_op(CMD_BCD2BIN, 64'h9999_9999_9999_9999, '0);
    send_op(CMD_BCD2BIN, 64'hA000_0000_0000_0000, '0);
    send_op(CMD_BCD2BIN, 64'h0000_0000_0000_000F, '0);
    send_op(CMD_BCD2BIN, '1, '0);
  endtask

  task automatic test_arithmetic();
    send_op(CMD_ADD, 64'h0, 64'h0);
    send_op(CMD_ADD, 64'h9999_9999_9999_9998, 64'h1);
    send_op(CMD_ADD, 64'h9999_9999_9999_9999, 64'h1);
    send_op(CMD_ADD, 64'h5000_0000_0000_0000, 64'h5000_0000_0000_0000);
    send_op(CMD_ADD, 64'h1, 64'h0000_00B0_0000_0000);
    send_op(CMD_ADD, '1, '1);
    send_op(CMD_MUL, 64'h0, 64'h9999_9999_9999_9999);
    send_op(CMD_MUL, 64'h9999_9999_9999_9999, 64'h1);
    send_op(CMD_MUL, 64'h9999_9999, 64'h1_0000_0001);
    send_op(CMD_MUL, 64'h1_0000_0000, 64'h1_0000_0000);
    send_op(CMD_MUL, 64'h1_0000_0000, 64'h1000_0000);
    send_op(CMD_MUL, 64'h3, 64'hC);
    // A bad digit wins over an overflowing product.
    send_op(CMD_MUL, 64'h9999_9999_9999_9999, 64'hF999_9999_9999_9999);
  endtask

  task automatic test_random(input int unsigned count);
    cmd_e        cmd;
    logic [63:0] a, b;
    for (int unsigned i = 0; i < count; i++) begin
      steady = (i >= count / 3 && i < count / 3 + 200);
      cmd = cmd_e'($urandom_range(3));
      case ($urandom_range(9))
        0:       begin a = {$urandom, $urandom}; b = {$urandom, $urandom}; end
        1:       begin a = rand_wide(); b = rand_wide(); end
        default: begin
          a = rand_bcd($urandom_range(16), 1'b1);
          b = rand_bcd($urandom_range(16), 1'b1);
          if (cmd == CMD_BIN2BCD && $urandom_range(1)) a = rand_wide();
        end
      endcase
      send_op(cmd, a, b);
    end
    steady = 1'b0;
  endtask

  // Output side: random stalls, and every beat checked against the oldest expectation.
  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && (steady || $urandom_range(99) >= 25);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat result=%h status=%0d", $time, m_axis_tdata,
                 m_axis_tuser);
        n_errors++;
      end else begin
        outcome_t exp_o;
        exp_o = pending_q.pop_front();
        if (m_axis_tdata !== exp_o.result) begin
          $display("%0t: result expected %h actual %h", $time, exp_o.result, m_axis_tdata);
          n_errors++;
        end
        if (m_axis_tuser !== exp_o.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_o.st, m_axis_tuser);
          n_errors++;
        end
        if (exp_o.st <= ST_OVF) st_hits[exp_o.st]++;
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats outstanding", $time, pending_q.size());
      $display("tb_bcd_conversion_arithmetic_unit: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_conversions();
    test_arithmetic();
    test_random(1950);
    end_stream();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("Sent %0d beats (b2d %0d, d2b %0d, add %0d, mul %0d), checked %0d.", n_sent,
             cmd_hits[0], cmd_hits[1], cmd_hits[2], cmd_hits[3], n_checked);
    $display("Outcomes seen: ok %0d, bad digit %0d, overflow %0d; %0d mismatches.",
             st_hits[0], st_hits[1], st_hits[2], n_errors);
    if (n_errors == 0) begin
      $display("tb_bcd_conversion_arithmetic_unit: PASS");
    end else begin
      $display("tb_bcd_conversion_arithmetic_unit: FAIL");
    end
    $finish;
  end

endmodule
